FILE: hdl/pfla_pkg.sv
package pfla_pkg;

    // Page geometry
    localparam int PAGE_SHIFT = 12;
    localparam int MAX_PAGES  = 32768;
    localparam int ADDR_W     = 32;
    localparam int LINK_W     = 16;
    localparam int PAGE_IDX_W = $clog2(MAX_PAGES);
    localparam int PG_NUM_W   = ADDR_W - PAGE_SHIFT;
    localparam int FB_W       = 28;

    localparam logic [LINK_W-1:0] NULL_PAGE = '1;
    localparam logic [FB_W-1:0]   FB_MAX    = '1;

    // Configuration register reset values
    localparam logic [ADDR_W-1:0] START_RESET = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] STOP_RESET  = 32'h8800_0000;

    // Configuration register indexes
    localparam logic CFG_REGION_START = 1'b0;
    localparam logic CFG_REGION_STOP  = 1'b1;

    // Operation codes
    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_FREE  = 2'd1,
        OP_ALLOC = 2'd2,
        OP_COUNT = 2'd3
    } t_op;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;
    localparam logic [1:0] ST_CAPACITY = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] page_address;
    } t_cmd_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted_address;
        logic [FB_W-1:0]   free_bytes;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic walk;
        logic emit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic walk_needed;
        logic walk_last;
    } t_dp_status;

endpackage

FILE: hdl/pfla_ctrl.sv
module pfla_ctrl
    import pfla_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WALK = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequence: take a beat, execute it, walk the pages for init
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.walk_needed) begin
                    n_state = S_WALK;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_last) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: hdl/pfla_dp.sv
module pfla_dp
    import pfla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd_in           i_cmd,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  t_ctrl_cmd         i_ctrl,
    output t_dp_status        o_status,
    output logic              o_done,
    output t_result           o_result
);

    // Configuration and list state
    logic [ADDR_W-1:0]     r_start;
    logic [ADDR_W-1:0]     r_stop;
    logic [ADDR_W-1:0]     r_base;
    logic [LINK_W-1:0]     r_head;
    logic [LINK_W-1:0]     r_free;

    // Beat in flight
    t_op                   r_op;
    logic [ADDR_W-1:0]     r_pa;

    // Init walk
    logic [PAGE_IDX_W-1:0] r_walk_cnt;
    logic [PAGE_IDX_W-1:0] r_walk_last;

    // Link memory
    logic [LINK_W-1:0]     r_next_page [MAX_PAGES];
    logic [LINK_W-1:0]     r_link;

    logic                  r_done;
    t_result               r_result;
    t_result               n_result;

    // Init arithmetic
    logic [ADDR_W:0]       init_round;
    logic [ADDR_W-1:0]     init_base;
    logic                  init_has_pages;
    logic [PG_NUM_W-1:0]   init_span;
    logic                  init_over;
    logic [PG_NUM_W-1:0]   init_pages;

    // Free checks
    logic [ADDR_W-1:0]     free_offset;
    logic [PG_NUM_W-1:0]   free_page_num;
    logic                  free_bad;

    // Alloc and count
    logic                  alloc_empty;
    logic [ADDR_W-1:0]     alloc_addr;
    logic [ADDR_W-1:0]     count_wide;
    logic [FB_W-1:0]       count_bytes;

    // Memory write port
    logic                  mem_we;
    logic [PAGE_IDX_W-1:0] mem_waddr;

    // Round the region start up and size the region
    always_comb begin
        init_round     = ({1'b0, r_start} + (ADDR_W+1)'((1 << PAGE_SHIFT) - 1))
                         & ~(ADDR_W+1)'((1 << PAGE_SHIFT) - 1);
        init_base      = init_round[ADDR_W-1:0];
        init_has_pages = !init_round[ADDR_W] && (r_stop > init_base);
        init_span      = init_has_pages ? PG_NUM_W'((r_stop - init_base) >> PAGE_SHIFT)
                                        : '0;
        init_over      = (init_span > PG_NUM_W'(MAX_PAGES));
        init_pages     = init_over ? PG_NUM_W'(MAX_PAGES) : init_span;
    end

    // Validate a freed address
    always_comb begin
        free_offset   = r_pa - r_base;
        free_page_num = free_offset[ADDR_W-1:PAGE_SHIFT];
        free_bad      = (r_pa[PAGE_SHIFT-1:0] != '0) || (r_pa < r_start) ||
                        (r_pa >= r_stop) || (r_pa < r_base) ||
                        (free_page_num >= PG_NUM_W'(MAX_PAGES));
    end

    // Pop address and byte count
    always_comb begin
        alloc_empty = (r_head >= LINK_W'(MAX_PAGES));
        alloc_addr  = r_base + (ADDR_W'(r_head[PAGE_IDX_W-1:0]) << PAGE_SHIFT);
        count_wide  = ADDR_W'(r_free) << PAGE_SHIFT;
        count_bytes = (count_wide > ADDR_W'(FB_MAX)) ? FB_MAX : count_wide[FB_W-1:0];
    end

    assign o_status.walk_needed = (r_op == OP_INIT) && (init_pages != '0);
    assign o_status.walk_last   = (r_walk_cnt == r_walk_last);

    // Link writes: pushes on free, page walk on init
    assign mem_we    = i_ctrl.walk || (i_ctrl.exec && (r_op == OP_FREE) && !free_bad);
    assign mem_waddr = i_ctrl.walk ? r_walk_cnt : free_page_num[PAGE_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_next_page[mem_waddr] <= r_head;
        end
        r_link <= r_next_page[r_head[PAGE_IDX_W-1:0]];
    end

    // Capture the beat
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_op <= t_op'(i_cmd.operation);
            r_pa <= i_cmd.page_address;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RESET;
            r_stop  <= STOP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REGION_START: r_start <= i_cfg_data;
                CFG_REGION_STOP:  r_stop  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Execute the beat and advance the list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= NULL_PAGE;
            r_free <= '0;
            r_base <= '0;
        end else if (i_ctrl.exec) begin
            unique case (r_op)
                OP_INIT: begin
                    r_base <= init_base;
                    r_head <= NULL_PAGE;
                    r_free <= '0;
                end
                OP_FREE: begin
                    if (!free_bad) begin
                        r_head <= LINK_W'(free_page_num[PAGE_IDX_W-1:0]);
                        if (r_free != '1) begin
                            r_free <= r_free + 1'b1;
                        end
                    end
                end
                OP_ALLOC: begin
                    if (!alloc_empty) begin
                        r_head <= r_link;
                        if (r_free != '0) begin
                            r_free <= r_free - 1'b1;
                        end
                    end
                end
                OP_COUNT: ;
                default: ;
            endcase
        end else if (i_ctrl.walk) begin
            r_head <= LINK_W'(r_walk_cnt);
            r_free <= r_free + 1'b1;
        end
    end

    // Walk counter for init
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_walk_cnt  <= '0;
            r_walk_last <= PAGE_IDX_W'(init_pages - 1'b1);
        end else if (i_ctrl.walk) begin
            r_walk_cnt  <= r_walk_cnt + 1'b1;
        end
    end

    // Form the result payload
    always_comb begin
        n_result = '0;
        unique case (r_op)
            OP_INIT: begin
                n_result.status = init_over ? ST_CAPACITY : ST_OK;
            end
            OP_FREE: begin
                n_result.status = free_bad ? ST_BAD_ADDR : ST_OK;
            end
            OP_ALLOC: begin
                if (alloc_empty) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    n_result.granted_address = alloc_addr;
                end
            end
            OP_COUNT: begin
                n_result.free_bytes = count_bytes;
            end
            default: ;
        endcase
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_result <= n_result;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctrl.emit;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: hdl/page_free_list_allocator_top.sv
// Channel   Handshake           Payload
// command   start / busy        i_cmd    (operation, page_address)
// result    o_done strobe       o_result (status, granted_address, free_bytes)
// config    i_cfg_we            i_cfg_index, i_cfg_data
//
// Free, alloc and count register the beat while the link of the head page is read
// from the link memory, then execute; the result strobes in the cycle after the
// execute step, while the next beat may already be taken.
// Init registers the beat, executes, then walks the n pages taken (up to 32768):
// the walk writes one link per cycle through the single memory write port.
// Reset is synchronous and active low; it leaves the list empty, no clearing pass.
// The receiver cannot stall: o_done strobes each result for one cycle only.
module page_free_list_allocator_top
    import pfla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_cmd_in           i_cmd,
    output logic              o_done,
    output t_result           o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // Sequencer
    pfla_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (ctrl_cmd)
    );

    // List state and link memory
    pfla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctrl      (ctrl_cmd),
        .o_status    (dp_status),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule
